// ===== sv/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with removal.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TAG_WIDTH_DEF = 16;

    // fixed field widths on the stream ports
    localparam int OPC_W     = 2;
    localparam int ITEM_W    = 16;
    localparam int POS_W     = 4;
    localparam int OUT_TAG_W = 16;
    localparam int OUT_CNT_W = 5;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [OPC_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_REMOVE_AT  = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_ctrl_state;

    // command from controller to datapath
    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage

// ===== sv/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Handshake controller: accepts a request whenever the result register is
// free or being drained, and tells the datapath to execute it.
// ----------------------------------------------------------------------------
module bdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output bdq_pkg::t_dp_cmd o_cmd
);
    import bdq_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                n_state = w_accept ? ST_HOLD : ST_IDLE;
            end
            ST_HOLD: begin
                // a new request can replace the result being taken
                if (w_accept) begin
                    n_state = ST_HOLD;
                end else if (i_out_ready) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        // no request is taken while reset is held
        o_in_ready  = i_rst_n && ((r_state == ST_IDLE) || i_out_ready);
        o_out_valid = (r_state == ST_HOLD);
        o_cmd.exec  = w_accept;
    end

endmodule

// ===== sv/bdq_datapath.sv =====
// ----------------------------------------------------------------------------
// bdq_datapath
// Shifting slot array, entry count and result register of the deque.
// ----------------------------------------------------------------------------
module bdq_datapath #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH = bdq_pkg::TAG_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bdq_pkg::t_dp_cmd                   i_cmd,
    input  logic [bdq_pkg::OPC_W-1:0]          i_opcode,
    input  logic [bdq_pkg::ITEM_W-1:0]         i_item_value,
    input  logic [bdq_pkg::POS_W-1:0]          i_position,
    output logic [bdq_pkg::OUT_TAG_W-1:0]      o_removed_value,
    output logic [bdq_pkg::OUT_TAG_W-1:0]      o_front_value,
    output logic [bdq_pkg::OUT_CNT_W-1:0]      o_entry_count,
    output logic                               o_is_empty,
    output logic                               o_op_error
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = CNT_W + POS_W;

    logic [TAG_WIDTH-1:0] r_slot [DEPTH];
    logic [TAG_WIDTH-1:0] n_slot [DEPTH];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;

    logic [OUT_TAG_W-1:0] r_removed;
    logic [OUT_TAG_W-1:0] r_front;
    logic [OUT_CNT_W-1:0] r_cnt_out;
    logic                 r_empty;
    logic                 r_error;

    logic [TAG_WIDTH+ITEM_W-1:0] w_tag_wide;
    logic [TAG_WIDTH-1:0]        w_tag;
    logic [CMP_W-1:0]            w_pos;
    logic [CMP_W-1:0]            w_cnt;
    logic                        w_err;
    logic [TAG_WIDTH-1:0]        w_removed;
    logic [TAG_WIDTH-1:0]        w_front;
    logic [TAG_WIDTH+OUT_TAG_W-1:0] w_rem_wide;
    logic [TAG_WIDTH+OUT_TAG_W-1:0] w_front_wide;
    logic [CNT_W+OUT_CNT_W-1:0]  w_cnt_wide;

    assign w_tag_wide = {{TAG_WIDTH{1'b0}}, i_item_value};
    assign w_tag      = w_tag_wide[TAG_WIDTH-1:0];
    assign w_cnt      = {{POS_W{1'b0}}, r_count};

    always_comb begin
        n_slot    = r_slot;
        n_count   = r_count;
        w_err     = 1'b0;
        w_removed = '0;
        w_pos     = {{CNT_W{1'b0}}, i_position};
        unique case (t_opcode'(i_opcode))
            OP_PUSH_BACK: begin
                if (w_cnt >= CMP_W'(DEPTH)) begin
                    w_err = 1'b1;
                end else begin
                    n_slot[r_count[IDX_W-1:0]] = w_tag;
                    n_count = r_count + 1'b1;
                end
            end
            OP_PUSH_FRONT: begin
                if (w_cnt >= CMP_W'(DEPTH)) begin
                    w_err = 1'b1;
                end else begin
                    for (int i = 1; i < DEPTH; i++) begin
                        n_slot[i] = r_slot[i-1];
                    end
                    n_slot[0] = w_tag;
                    n_count = r_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_REMOVE_AT: begin
                // a pop is a removal at the front
                if (t_opcode'(i_opcode) == OP_POP_FRONT) begin
                    w_pos = '0;
                end
                if (w_pos >= w_cnt) begin
                    w_err = 1'b1;
                end else begin
                    w_removed = r_slot[w_pos[IDX_W-1:0]];
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (CMP_W'(i) >= w_pos) begin
                            n_slot[i] = r_slot[i+1];
                        end
                    end
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                w_err = 1'b1;
            end
        endcase
        w_front = (n_count != '0) ? n_slot[0] : '0;
    end

    assign w_rem_wide   = {{OUT_TAG_W{1'b0}}, w_removed};
    assign w_front_wide = {{OUT_TAG_W{1'b0}}, w_front};
    assign w_cnt_wide   = {{OUT_CNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec && !w_err) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !w_err) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_removed <= w_rem_wide[OUT_TAG_W-1:0];
            r_front   <= w_front_wide[OUT_TAG_W-1:0];
            r_cnt_out <= w_cnt_wide[OUT_CNT_W-1:0];
            r_empty   <= (n_count == '0);
            r_error   <= w_err;
        end
    end

    assign o_removed_value = r_removed;
    assign o_front_value   = r_front;
    assign o_entry_count   = r_cnt_out;
    assign o_is_empty      = r_empty;
    assign o_op_error      = r_error;

endmodule

// ===== sv/bounded_deque_with_removal_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_removal_unit
// Bounded double-ended queue of tags with pop and removal at a position.
// ----------------------------------------------------------------------------
// usage:
//   requests enter on the s_axis channel: tuser carries the opcode (push
//   back, push front, pop front, remove at position), tdata the tag and the
//   position. every request yields exactly one result on m_axis: the tag
//   removed, the new front tag, the entry count, an empty flag and an error
//   flag. a refused request (push when full, pop when empty, position at or
//   beyond the count) sets the error flag and leaves the contents alone.
//   the result is registered and appears in the cycle after the request is
//   taken; one request per cycle is sustained while m_axis_tready stays high.
//   a new request is taken while the previous result is being accepted.
//   when the receiver stalls the result register holds and s_axis_tready
//   drops until the result is taken.
//   reset empties the queue (count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module bounded_deque_with_removal_unit #(
    parameter int DEPTH     = bdq_pkg::DEPTH_DEF,
    parameter int TAG_WIDTH = bdq_pkg::TAG_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // item_value [15:0], position [19:16], zero pad [23:20]
    input  logic [bdq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode [1:0]
    input  logic [bdq_pkg::OPC_W-1:0]         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // removed_value [15:0], front_value [31:16], entry_count [36:32],
    // is_empty [37], op_error [38], zero pad [39]
    output logic [bdq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import bdq_pkg::*;

    t_dp_cmd              w_cmd;
    logic [OUT_TAG_W-1:0] w_removed;
    logic [OUT_TAG_W-1:0] w_front;
    logic [OUT_CNT_W-1:0] w_count;
    logic                 w_empty;
    logic                 w_error;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    bdq_datapath #(
        .DEPTH     (DEPTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (s_axis_tuser),
        .i_item_value    (s_axis_tdata[ITEM_W-1:0]),
        .i_position      (s_axis_tdata[ITEM_W+POS_W-1:ITEM_W]),
        .o_removed_value (w_removed),
        .o_front_value   (w_front),
        .o_entry_count   (w_count),
        .o_is_empty      (w_empty),
        .o_op_error      (w_error)
    );

    assign m_axis_tdata = {1'b0, w_error, w_empty, w_count, w_front, w_removed};

endmodule
